// ===== hw/rtl/pli_pkg.sv =====
`timescale 1ns / 1ps

package pli_pkg;

  localparam int CenW       = 10;
  localparam int DatW       = 16;
  localparam int PtW        = 32;
  localparam int CfgIdxW    = 3;
  localparam int CfgDataW   = 32;
  localparam int MaxPoints  = 4;
  localparam int NumPointsDef = 4;

  // fraction t, 16 quotient bits, four per stage
  localparam int TW           = 16;
  localparam int DivStepsPerSt = 4;
  localparam int DivStages    = TW / DivStepsPerSt;

  // root of a 32-bit word, 16 root bits, four per stage
  localparam int RadW          = 32;
  localparam int RootW         = 16;
  localparam int RemW          = RootW + 2;
  localparam int SqrtStepsPerSt = 4;
  localparam int SqrtStages    = RootW / SqrtStepsPerSt;

  localparam logic [CenW-1:0] CentreRst [MaxPoints] = '{
    CenW'(50), CenW'(200), CenW'(400), CenW'(650)
  };

  typedef enum logic [CfgIdxW-1:0] {
    CfgCentre0 = 3'd0,
    CfgCentre1 = 3'd1,
    CfgCentre2 = 3'd2,
    CfgCentre3 = 3'd3,
    CfgPoint0  = 3'd4,
    CfgPoint1  = 3'd5,
    CfgPoint2  = 3'd6,
    CfgPoint3  = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [DatW-1:0] val_l;
    logic [DatW-1:0] err_l;
    logic [DatW-1:0] val_r;
    logic [DatW-1:0] err_r;
    logic            held;
  } pts_t;

  typedef struct packed {
    logic [CenW-1:0] rem;
    logic [CenW-1:0] den;
    logic [TW-1:0]   quo;
    pts_t            pts;
  } div_t;

  typedef struct packed {
    logic [RadW-1:0]  rad;
    logic [RemW-1:0]  rem;
    logic [RootW-1:0] root;
    logic [DatW-1:0]  val;
    logic             held;
  } sqrt_t;

  // restoring division, one quotient bit per step; rem stays below den
  function automatic div_t div_steps(div_t x);
    div_t        r;
    logic [CenW:0] sh;
    r = x;
    for (int i = 0; i < DivStepsPerSt; i++) begin
      sh = {r.rem, 1'b0};
      if (sh >= {1'b0, r.den}) begin
        r.rem = CenW'(sh - {1'b0, r.den});
        r.quo = {r.quo[TW-2:0], 1'b1};
      end else begin
        r.rem = sh[CenW-1:0];
        r.quo = {r.quo[TW-2:0], 1'b0};
      end
    end
    return r;
  endfunction

  // digit-by-digit square root, two radicand bits per step
  function automatic sqrt_t sqrt_steps(sqrt_t x);
    sqrt_t         r;
    logic [RemW+1:0] tmp;
    logic [RemW+1:0] tst;
    r = x;
    for (int i = 0; i < SqrtStepsPerSt; i++) begin
      tmp = {r.rem, r.rad[RadW-1 -: 2]};
      tst = (RemW+2)'({r.root, 2'b01});
      r.rad = {r.rad[RadW-3:0], 2'b00};
      if (tmp >= tst) begin
        r.rem  = RemW'(tmp - tst);
        r.root = {r.root[RootW-2:0], 1'b1};
      end else begin
        r.rem  = tmp[RemW-1:0];
        r.root = {r.root[RootW-2:0], 1'b0};
      end
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/pli_sel.sv =====
`timescale 1ns / 1ps

module pli_sel #(
  parameter int NumPoints = pli_pkg::NumPointsDef
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    vld_i,
  input  logic [pli_pkg::CenW-1:0] query_i,
  input  logic [pli_pkg::CenW-1:0] centre_i [pli_pkg::MaxPoints],
  input  logic [pli_pkg::PtW-1:0]  point_i  [pli_pkg::MaxPoints],
  output logic                    vld_o,
  output pli_pkg::div_t           div_o
);
  import pli_pkg::*;

  localparam logic [1:0] LastIdx = 2'(NumPoints - 1);

  logic [1:0] j;
  logic [1:0] lidx;
  logic       flat;
  div_t       div_d, div_q;
  logic       vld_q;

  always_comb begin
    j = 2'd0;
    for (int k = 0; k < 2; k++) begin
      if ((k + 2 < NumPoints) && (j == 2'(k)) && (query_i > centre_i[k+1])) begin
        j = 2'(k + 1);
      end
    end
    flat           = 1'b0;
    lidx           = j;
    div_d.rem      = '0;
    div_d.den      = CenW'(1);
    div_d.quo      = '0;
    div_d.pts.held = 1'b0;
    if (query_i <= centre_i[0]) begin
      lidx = 2'd0;
      flat = 1'b1;
    end else if (query_i >= centre_i[LastIdx]) begin
      lidx           = LastIdx;
      flat           = 1'b1;
      div_d.pts.held = query_i > centre_i[LastIdx];
    end else if (centre_i[j + 2'd1] <= centre_i[j]) begin
      flat = 1'b1;
    end else if (query_i == centre_i[j + 2'd1]) begin
      // t = 1.0 does not fit the quotient; take the right point instead
      lidx = j + 2'd1;
      flat = 1'b1;
    end
    if (!flat) begin
      div_d.rem = query_i - centre_i[j];
      div_d.den = centre_i[j + 2'd1] - centre_i[j];
    end
    // t = 0 picks the left point exactly
    div_d.pts.val_l = point_i[lidx][PtW-1:DatW];
    div_d.pts.err_l = point_i[lidx][DatW-1:0];
    div_d.pts.val_r = point_i[lidx + 2'd1][PtW-1:DatW];
    div_d.pts.err_r = point_i[lidx + 2'd1][DatW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    div_q <= div_d;
  end

  assign vld_o = vld_q;
  assign div_o = div_q;

endmodule

// ===== hw/rtl/pli_div.sv =====
`timescale 1ns / 1ps

module pli_div (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          vld_i,
  input  pli_pkg::div_t div_i,
  output logic          vld_o,
  output pli_pkg::div_t div_o
);
  import pli_pkg::*;

  div_t st_q  [DivStages];
  logic vld_q [DivStages];

  for (genvar s = 0; s < DivStages; s++) begin : g_st
    div_t st_d;
    logic vld_d;
    if (s == 0) begin : g_first
      assign st_d  = div_steps(div_i);
      assign vld_d = vld_i;
    end else begin : g_next
      assign st_d  = div_steps(st_q[s-1]);
      assign vld_d = vld_q[s-1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else begin
        vld_q[s] <= vld_d;
      end
    end

    always_ff @(posedge clk_i) begin
      st_q[s] <= st_d;
    end
  end

  assign vld_o = vld_q[DivStages-1];
  assign div_o = st_q[DivStages-1];

endmodule

// ===== hw/rtl/pli_mac.sv =====
`timescale 1ns / 1ps

module pli_mac (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           vld_i,
  input  pli_pkg::div_t  div_i,
  output logic           vld_o,
  output pli_pkg::sqrt_t sqrt_o
);
  import pli_pkg::*;

  localparam logic [TW:0] OneQ = {1'b1, {TW{1'b0}}};

  // stage 1: weights times values and errors
  logic [TW:0]     u;
  logic [32:0]     pva_w, pvb_w, ea_w, eb_w;
  logic [31:0]     pva_q, pvb_q, ea_q, eb_q;
  logic            h1_q;
  // stage 2: blend value, square error terms
  logic [32:0]     vsum;
  logic [DatW-1:0] val_d, val2_q, val3_q;
  logic [63:0]     aa_d, bb_d, aa_q, bb_q;
  logic            h2_q, h3_q;
  // stage 3: sum of squares, keep the top word
  logic [64:0]     ssum;
  logic [RadW-1:0] rad_q;
  logic [2:0]      vld_q;

  assign u     = OneQ - {1'b0, div_i.quo};
  assign pva_w = u * div_i.pts.val_l;
  assign pvb_w = div_i.quo * div_i.pts.val_r;
  assign ea_w  = u * div_i.pts.err_l;
  assign eb_w  = div_i.quo * div_i.pts.err_r;

  assign vsum  = {1'b0, pva_q} + {1'b0, pvb_q};
  assign val_d = vsum[32] ? {DatW{1'b1}} : vsum[31:16];
  assign aa_d  = ea_q * ea_q;
  assign bb_d  = eb_q * eb_q;

  assign ssum  = {1'b0, aa_q} + {1'b0, bb_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[1:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    pva_q  <= pva_w[31:0];
    pvb_q  <= pvb_w[31:0];
    ea_q   <= ea_w[31:0];
    eb_q   <= eb_w[31:0];
    h1_q   <= div_i.pts.held;
    val2_q <= val_d;
    aa_q   <= aa_d;
    bb_q   <= bb_d;
    h2_q   <= h1_q;
    rad_q  <= ssum[63:32];
    val3_q <= val2_q;
    h3_q   <= h2_q;
  end

  assign vld_o       = vld_q[2];
  assign sqrt_o.rad  = rad_q;
  assign sqrt_o.rem  = '0;
  assign sqrt_o.root = '0;
  assign sqrt_o.val  = val3_q;
  assign sqrt_o.held = h3_q;

endmodule

// ===== hw/rtl/pli_sqrt.sv =====
`timescale 1ns / 1ps

module pli_sqrt (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           vld_i,
  input  pli_pkg::sqrt_t sqrt_i,
  output logic           vld_o,
  output pli_pkg::sqrt_t sqrt_o
);
  import pli_pkg::*;

  sqrt_t st_q  [SqrtStages];
  logic  vld_q [SqrtStages];

  for (genvar s = 0; s < SqrtStages; s++) begin : g_st
    sqrt_t st_d;
    logic  vld_d;
    if (s == 0) begin : g_first
      assign st_d  = sqrt_steps(sqrt_i);
      assign vld_d = vld_i;
    end else begin : g_next
      assign st_d  = sqrt_steps(st_q[s-1]);
      assign vld_d = vld_q[s-1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else begin
        vld_q[s] <= vld_d;
      end
    end

    always_ff @(posedge clk_i) begin
      st_q[s] <= st_d;
    end
  end

  assign vld_o  = vld_q[SqrtStages-1];
  assign sqrt_o = st_q[SqrtStages-1];

endmodule

// ===== hw/rtl/piecewise_linear_interp_with_error_top.sv =====
`timescale 1ns / 1ps

// Piecewise linear interpolation with error propagation over up to four
// breakpoints. Pulse start_i with query_centre_i to issue a request; busy_o
// stays low, so a request may be issued every cycle. Each request yields one
// result, shown for exactly one cycle with done_o high; results come out in
// request order and the receiver cannot hold them off. The pipeline has one
// segment select stage, four stages of a 16-bit restoring divider that forms
// t, three multiply stages and four stages of a 16-bit digit square root.
// Write breakpoints only while no request is in flight.
module piecewise_linear_interp_with_error_top #(
  parameter int NumPoints = pli_pkg::NumPointsDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic [pli_pkg::CenW-1:0]    query_centre_i,
  output logic                        done_o,
  output logic [pli_pkg::DatW-1:0]    interp_value_o,
  output logic [pli_pkg::DatW-1:0]    interp_error_o,
  output logic                        held_flat_o,
  input  logic                        cfg_we_i,
  input  logic [pli_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [pli_pkg::CfgDataW-1:0] cfg_data_i
);
  import pli_pkg::*;

  // breakpoint registers
  logic [CenW-1:0] centre_q [MaxPoints];
  logic [PtW-1:0]  point_q  [MaxPoints];

  logic  sel_vld, div_vld, mac_vld, sqrt_vld;
  div_t  sel_div, div_res;
  sqrt_t mac_res, sqrt_res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < MaxPoints; k++) begin
        centre_q[k] <= CentreRst[k];
        point_q[k]  <= '0;
      end
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CfgCentre0: centre_q[0] <= cfg_data_i[CenW-1:0];
        CfgCentre1: centre_q[1] <= cfg_data_i[CenW-1:0];
        CfgCentre2: centre_q[2] <= cfg_data_i[CenW-1:0];
        CfgCentre3: centre_q[3] <= cfg_data_i[CenW-1:0];
        CfgPoint0:  point_q[0]  <= cfg_data_i[PtW-1:0];
        CfgPoint1:  point_q[1]  <= cfg_data_i[PtW-1:0];
        CfgPoint2:  point_q[2]  <= cfg_data_i[PtW-1:0];
        CfgPoint3:  point_q[3]  <= cfg_data_i[PtW-1:0];
        default: ;
      endcase
    end
  end

  // every stage advances each cycle, so a request is always taken
  assign busy_o = 1'b0;

  // pick the segment; out-of-segment queries enter with t forced to zero
  pli_sel #(
    .NumPoints(NumPoints)
  ) u_sel (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .vld_i   (start_i),
    .query_i (query_centre_i),
    .centre_i(centre_q),
    .point_i (point_q),
    .vld_o   (sel_vld),
    .div_o   (sel_div)
  );

  // form t = offset / span in Q0.16
  pli_div u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .vld_i (sel_vld),
    .div_i (sel_div),
    .vld_o (div_vld),
    .div_o (div_res)
  );

  // blend the value, square and sum the weighted errors
  pli_mac u_mac (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .vld_i (div_vld),
    .div_i (div_res),
    .vld_o (mac_vld),
    .sqrt_o(mac_res)
  );

  // root of the top word of the sum equals the full root shifted down by 16
  pli_sqrt u_sqrt (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .vld_i (mac_vld),
    .sqrt_i(mac_res),
    .vld_o (sqrt_vld),
    .sqrt_o(sqrt_res)
  );

  assign done_o         = sqrt_vld;
  assign interp_value_o = sqrt_res.val;
  assign interp_error_o = sqrt_res.root;
  assign held_flat_o    = sqrt_res.held;

endmodule
